// ===== sv/ppr_pkg.sv =====
// ----------------------------------------------------------------------------
// ppr_pkg
// Shared types, codes and helpers of the ping-pong read prefetch block.
// ----------------------------------------------------------------------------
package ppr_pkg;

  localparam int unsigned BUFFER_BYTES_DEF = 16384;

  typedef enum logic [0:0] {
    CMD_SEEK = 1'b0,
    CMD_READ = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_FETCH   = 2'd0,
    KIND_SEGMENT = 2'd1,
    KIND_DONE    = 2'd2
  } kind_e;

  // One input item as held in the input register.
  typedef struct packed {
    logic        cmd;
    logic [15:0] slot_id;
    logic [31:0] position_or_count;
    logic [31:0] request_size;
    logic [31:0] slot_length;
  } item_t;

  // One result record.
  typedef struct packed {
    kind_e       kind;
    logic        sel;
    logic [31:0] pos;
    logic [31:0] cnt;
    logic        bg;
    logic        last;
  } rec_t;

  // All records caused by one item, with their count (1 to 3).
  typedef struct packed {
    rec_t [2:0] recs;
    logic [1:0] n;
  } plan_t;

  function automatic rec_t mk_rec(kind_e kind, logic sel, logic [31:0] pos,
                                  logic [31:0] cnt, logic bg);
    rec_t r;
    r.kind = kind;
    r.sel  = sel;
    r.pos  = pos;
    r.cnt  = cnt;
    r.bg   = bg;
    r.last = 1'b0;
    return r;
  endfunction

endpackage

// ===== sv/ppr_in_if.sv =====
// ----------------------------------------------------------------------------
// ppr_in_if
// Request channel: seek and read items with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ppr_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [15:0] slot_id;
  logic [31:0] position_or_count;
  logic [31:0] request_size;
  logic [31:0] slot_length;

  modport source (
    output valid, cmd, slot_id, position_or_count, request_size, slot_length,
    input  ready
  );
  modport sink (
    input  valid, cmd, slot_id, position_or_count, request_size, slot_length,
    output ready
  );
endinterface

// ===== sv/ppr_out_if.sv =====
// ----------------------------------------------------------------------------
// ppr_out_if
// Record channel: fetch requests, copy segments and seek-done records.
// ----------------------------------------------------------------------------
interface ppr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  record_kind;
  logic        buffer_sel;
  logic [31:0] position;
  logic [31:0] byte_count;
  logic        in_background;
  logic        last;

  modport source (
    output valid, record_kind, buffer_sel, position, byte_count, in_background,
           last,
    input  ready
  );
  modport sink (
    input  valid, record_kind, buffer_sel, position, byte_count, in_background,
           last,
    output ready
  );
endinterface

// ===== sv/ping_pong_read_prefetch_core.sv =====
// ----------------------------------------------------------------------------
// ping_pong_read_prefetch_core
// Two-buffer read-ahead controller: seek and read items in, fetch, segment
// and seek-done records out.
// ----------------------------------------------------------------------------
// An item is taken into an input register, planned against the buffer state
// once the record register is free, and its records (one to three) are
// handed out one per cycle, while the record port is ready, from a record
// register. A seek gives up to two fetch requests and a seek done; a read
// gives one or two copy segments. The next item is accepted while the
// previous item's records drain, the record port being the limit.
module ping_pong_read_prefetch_core
  import ppr_pkg::*;
#(
  parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ppr_in_if.sink    in_i,
  ppr_out_if.source out_o
);

  logic  in_valid_q;
  item_t item_q;
  logic  emit_free;
  logic  fire;
  plan_t plan;

  assign fire      = in_valid_q && emit_free;
  assign in_i.ready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q.cmd               <= in_i.cmd;
      item_q.slot_id           <= in_i.slot_id;
      item_q.position_or_count <= in_i.position_or_count;
      item_q.request_size      <= in_i.request_size;
      item_q.slot_length       <= in_i.slot_length;
    end
  end

  ppr_ctrl #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .fire_i(fire),
    .item_i(item_q),
    .plan_o(plan)
  );

  ppr_emit u_emit (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .load_i(fire),
    .plan_i(plan),
    .free_o(emit_free),
    .out_o (out_o)
  );

endmodule

// ===== sv/ppr_ctrl.sv =====
// ----------------------------------------------------------------------------
// ppr_ctrl
// Buffer bookkeeping: hit and refill decisions, state update and the list
// of records that one item produces.
// ----------------------------------------------------------------------------
module ppr_ctrl
  import ppr_pkg::*;
#(
  parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  fire_i,
  input  item_t item_i,
  output plan_t plan_o
);

  localparam int unsigned SW = $clog2(BUFFER_BYTES);
  localparam logic [31:0] B32 = 32'(BUFFER_BYTES);
  localparam logic [32:0] B33 = 33'(BUFFER_BYTES);

  logic [15:0]   cached_slot_q, cached_slot_d;
  logic [31:0]   base0_q, base0_d;
  logic [31:0]   base1_q, base1_d;
  logic          active_q, active_d;
  logic [SW-1:0] start_q, start_d;
  logic [31:0]   size_q, size_d;
  logic          pf_q, pf_d;

  // Bytes left to fetch from a file offset, capped at one buffer.
  function automatic logic [31:0] fetch_len(logic [31:0] slen, logic [31:0] off);
    logic [31:0] left;
    left = slen - off;
    if (off >= slen) return '0;
    return (left >= B32) ? B32 : left;
  endfunction

  logic [31:0] off, size, slen, cnt;
  logic [32:0] end33, top0, top1;
  logic        min0, min1, fit0, fit1, hit0, hit1, swap0, swap1;
  logic        same, pf_eff, refill, pick0, over;
  logic [31:0] room, first;

  assign off  = item_i.position_or_count;
  assign cnt  = item_i.position_or_count;
  assign size = item_i.request_size;
  assign slen = item_i.slot_length;

  assign end33 = {1'b0, off} + {1'b0, size};
  assign top0  = {1'b0, base0_q} + B33;
  assign top1  = {1'b0, base1_q} + B33;
  assign min0  = off >= base0_q;
  assign min1  = off >= base1_q;
  assign fit0  = end33 < top0;
  assign fit1  = end33 < top1;
  assign hit0  = fit0 && min0;
  assign hit1  = fit1 && min1;
  // A request that starts in one buffer and runs into the buffer behind it.
  assign swap0 = min0 && fit1 && !min1 && (top0 == {1'b0, base1_q});
  assign swap1 = min1 && fit0 && !min0 && (top1 == {1'b0, base0_q});
  assign same  = item_i.slot_id == cached_slot_q;
  // Moving to the other buffer re-arms the prefetch of the one just left.
  assign pf_eff = pf_q && !(same && ((hit0 && active_q) || (hit1 && !active_q)));
  assign refill = !same || !(hit0 || hit1 || swap0 || swap1);
  assign pick0  = hit0 || swap0;

  assign over  = ({1'b0, 32'(start_q)} + {1'b0, size_q}) >= B33;
  assign room  = B32 - 32'(start_q);
  assign first = (cnt < room) ? cnt : room;

  always_comb begin
    plan_t       p;
    logic [1:0]  n;
    logic [31:0] nb;
    p             = '0;
    n             = 2'd0;
    nb            = '0;
    cached_slot_d = cached_slot_q;
    base0_d       = base0_q;
    base1_d       = base1_q;
    active_d      = active_q;
    start_d       = start_q;
    size_d        = size_q;
    pf_d          = pf_q;
    if (item_i.cmd == CMD_READ) begin
      if (over) begin
        p.recs[0] = mk_rec(KIND_SEGMENT, active_q, 32'(start_q), first, 1'b0);
        p.recs[1] = mk_rec(KIND_SEGMENT, ~active_q, '0, cnt - first, 1'b0);
        n         = 2'd2;
      end else begin
        p.recs[0] = mk_rec(KIND_SEGMENT, active_q, 32'(start_q), cnt, 1'b0);
        n         = 2'd1;
      end
    end else begin
      pf_d = 1'b1;
      priority if (refill) begin
        size_d        = size;
        cached_slot_d = item_i.slot_id;
        base0_d       = off;
        base1_d       = '0;
        active_d      = 1'b0;
        start_d       = '0;
        p.recs[0]     = mk_rec(KIND_FETCH, 1'b0, off, fetch_len(slen, off), 1'b0);
        n             = 2'd1;
        if (slen > B32) begin
          nb        = off + B32;
          base1_d   = nb;
          p.recs[1] = mk_rec(KIND_FETCH, 1'b1, nb, fetch_len(slen, nb), 1'b1);
          n         = 2'd2;
        end
      end else if (pick0) begin
        active_d = 1'b0;
        start_d  = SW'(off - base0_q);
        if (!pf_eff) begin
          nb        = base0_q + B32;
          base1_d   = nb;
          p.recs[0] = mk_rec(KIND_FETCH, 1'b1, nb, fetch_len(slen, nb), 1'b1);
          n         = 2'd1;
        end
      end else begin
        active_d = 1'b1;
        start_d  = SW'(off - base1_q);
        if (!pf_eff) begin
          nb        = base1_q + B32;
          base0_d   = nb;
          p.recs[0] = mk_rec(KIND_FETCH, 1'b0, nb, fetch_len(slen, nb), 1'b1);
          n         = 2'd1;
        end
      end
      p.recs[n] = mk_rec(KIND_DONE, active_d, 32'(start_d), '0, 1'b0);
      n         = n + 2'd1;
    end
    for (int k = 0; k < 3; k++) begin
      p.recs[k].last = (2'(k) == n - 2'd1);
    end
    p.n    = n;
    plan_o = p;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cached_slot_q <= '0;
      base0_q       <= '0;
      base1_q       <= '0;
      active_q      <= 1'b0;
      start_q       <= '0;
      size_q        <= '0;
      pf_q          <= 1'b0;
    end else if (fire_i) begin
      cached_slot_q <= cached_slot_d;
      base0_q       <= base0_d;
      base1_q       <= base1_d;
      active_q      <= active_d;
      start_q       <= start_d;
      size_q        <= size_d;
      pf_q          <= pf_d;
    end
  end

`ifndef SYNTHESIS
  a_read_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && item_i.cmd == CMD_READ |-> plan_o.n == 2'd1 || plan_o.n == 2'd2)
    else $error("read item must give one or two segments");

  a_one_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i |-> $countones({plan_o.recs[2].last, plan_o.recs[1].last,
                           plan_o.recs[0].last}) == 1)
    else $error("exactly one record of an item must carry last");

  a_seek_arms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && item_i.cmd == CMD_SEEK |=> pf_q)
    else $error("prefetch flag must be set after a seek");
`endif

endmodule

// ===== sv/ppr_emit.sv =====
// ----------------------------------------------------------------------------
// ppr_emit
// Record register: holds the records of one item and hands them out one per
// handshake, taking the next item's records as the last one leaves.
// ----------------------------------------------------------------------------
module ppr_emit
  import ppr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  plan_t            plan_i,
  output logic             free_o,
  ppr_out_if.source        out_o
);

  logic       valid_q;
  logic [1:0] idx_q;
  plan_t      plan_q;
  rec_t       rec;
  logic       pop, pop_last;

  assign rec      = plan_q.recs[idx_q];
  assign pop      = valid_q && out_o.ready;
  assign pop_last = pop && rec.last;
  assign free_o   = !valid_q || pop_last;

  assign out_o.valid         = valid_q;
  assign out_o.record_kind   = rec.kind;
  assign out_o.buffer_sel    = rec.sel;
  assign out_o.position      = rec.pos;
  assign out_o.byte_count    = rec.cnt;
  assign out_o.in_background = rec.bg;
  assign out_o.last          = rec.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
    end else if (pop_last) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (pop) begin
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      plan_q <= plan_i;
    end
  end

`ifndef SYNTHESIS
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> idx_q < plan_q.n)
    else $error("record index beyond record count");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("records loaded over undelivered records");

  a_keep_going: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !rec.last |=> valid_q && idx_q == $past(idx_q) + 2'd1)
    else $error("records of an item must follow without a gap");
`endif

endmodule
